@@ hdl/imd_pkg.sv @@
// ---------------------------------------------------------------------------
// imd_pkg: shared types and constants of the IMU motion detector
// Field widths, register indexes, reset values and the sequencer states.
// ---------------------------------------------------------------------------
package imd_pkg;

  // Largest window in valid samples (default of the top-level parameter)
  localparam int MAX_WINDOW_DEF = 1024;

  // Field widths
  localparam int SAMPLE_W   = 16;  // one signed IMU axis
  localparam int NORM_W     = 32;  // sum of three squares of a sample
  localparam int ROOT_W     = 16;  // integer square root of NORM_W bits
  localparam int QUOT_W     = 32;  // quotient of the window divisions
  localparam int TH_W       = 16;  // threshold registers
  localparam int VCNT_W     = 11;  // reported valid sample count
  localparam int CFG_IDX_W  = 4;   // configuration register index
  localparam int IN_TDATA_W = 96;  // six axes
  localparam int OUT_TDATA_W = 48; // accel_std, gyro_rms, valid_count, pad

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STD_TH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_RMS_TH  = 4'd1;

  // Threshold reset values: 0.02 g in 1/4096 g, 8 dps in 1/16 dps
  localparam logic [TH_W-1:0] ACCEL_STD_TH_RST = 16'd82;
  localparam logic [TH_W-1:0] GYRO_RMS_TH_RST  = 16'd128;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // wait for a sample
    ST_SQ,     // squared norms of accel and gyro
    ST_ROOT,   // accel magnitude root
    ST_MSQ,    // magnitude squared, then accumulate
    ST_WCHK,   // window end: check for an empty window
    ST_WP,     // n * S2
    ST_WQ,     // S1 * S1
    ST_WNN,    // n * n
    ST_WDA,    // accel variance division
    ST_WRA,    // accel std root
    ST_WDG,    // gyro mean square division
    ST_WRG,    // gyro rms root
    ST_OUT     // hand the result to the output register
  } st_e;

endpackage

@@ hdl/imd_sqnorm.sv @@
// ---------------------------------------------------------------------------
// imd_sqnorm: bit-serial sum of three squares
// Squares three signed axes at once, one multiplier bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module imd_sqnorm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [imd_pkg::SAMPLE_W-1:0] x_i,
  input  logic signed [imd_pkg::SAMPLE_W-1:0] y_i,
  input  logic signed [imd_pkg::SAMPLE_W-1:0] z_i,
  output logic                                done_o,
  output logic [imd_pkg::NORM_W-1:0]          norm_o
);

  localparam int SW    = imd_pkg::SAMPLE_W;
  localparam int NW    = imd_pkg::NORM_W;
  localparam int CNT_W = $clog2(SW);

  function automatic logic [SW-1:0] abs_val(logic signed [SW-1:0] v);
    logic [SW-1:0] u;
    u = v;
    return v[SW-1] ? SW'(~u + 1'b1) : u;
  endfunction

  logic [SW-1:0]    ax_q, ay_q, az_q;
  logic [SW-1:0]    bx_q, by_q, bz_q;
  logic [SW-1:0]    bx_d, by_d, bz_d;
  logic [NW-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // Shift-and-add step on all three axes
  always_comb begin
    acc_d  = acc_q;
    bx_d   = bx_q;
    by_d   = by_q;
    bz_d   = bz_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      bx_d   = abs_val(x_i);
      by_d   = abs_val(y_i);
      bz_d   = abs_val(z_i);
      cnt_d  = CNT_W'(SW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[NW-2:0], 1'b0}
            + (bx_q[SW-1] ? NW'(ax_q) : '0)
            + (by_q[SW-1] ? NW'(ay_q) : '0)
            + (bz_q[SW-1] ? NW'(az_q) : '0);
      bx_d  = {bx_q[SW-2:0], 1'b0};
      by_d  = {by_q[SW-2:0], 1'b0};
      bz_d  = {bz_q[SW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ax_q <= abs_val(x_i);
      ay_q <= abs_val(y_i);
      az_q <= abs_val(z_i);
    end
    bx_q  <= bx_d;
    by_q  <= by_d;
    bz_q  <= bz_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign norm_o = acc_q;

endmodule

@@ hdl/imd_isqrt.sv @@
// ---------------------------------------------------------------------------
// imd_isqrt: digit-by-digit integer square root
// Produces one root bit per cycle from two radicand bits, floor result.
// ---------------------------------------------------------------------------
module imd_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [imd_pkg::NORM_W-1:0]  arg_i,
  output logic                        done_o,
  output logic [imd_pkg::ROOT_W-1:0]  root_o
);

  localparam int NW    = imd_pkg::NORM_W;
  localparam int RTW   = imd_pkg::ROOT_W;
  localparam int RW    = RTW + 2;   // partial remainder, at most 2*root
  localparam int TW    = RW + 2;    // remainder with the next two bits
  localparam int CNT_W = $clog2(RTW);

  logic [NW-1:0]    v_q, v_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [RTW-1:0]   root_q, root_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [TW-1:0]    part;
  logic [TW-1:0]    trial;
  logic             fits;

  assign part  = {rem_q, v_q[NW-1 -: 2]};
  assign trial = TW'({root_q, 2'b01});
  assign fits  = part >= trial;

  // Next root bit
  always_comb begin
    v_d    = v_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = arg_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(RTW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      v_d    = {v_q[NW-3:0], 2'b00};
      rem_d  = fits ? RW'(part - trial) : part[RW-1:0];
      root_d = {root_q[RTW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hdl/imd_mul.sv @@
// ---------------------------------------------------------------------------
// imd_mul: bit-serial unsigned multiplier
// Adds the multiplicand once per multiplier bit, MSB first.
// ---------------------------------------------------------------------------
module imd_mul #(
  parameter int AW = 16,  // multiplicand width
  parameter int BW = 16,  // multiplier width, one bit per cycle
  parameter int PW = 32   // product width, wide enough for the products used
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [PW-1:0] prod_o
);

  localparam int CNT_W = $clog2(BW);

  logic [AW-1:0]    a_q;
  logic [BW-1:0]    b_q, b_d;
  logic [PW-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // Shift-and-add step
  always_comb begin
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = CNT_W'(BW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[PW-2:0], 1'b0} + (b_q[BW-1] ? PW'(a_q) : '0);
      b_d   = {b_q[BW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ hdl/imd_div.sv @@
// ---------------------------------------------------------------------------
// imd_div: restoring divider, one quotient bit per cycle
// The caller guarantees the quotient fits QUOT_W bits, so the remainder
// starts from the dividend bits above the quotient and stays below 2*divisor.
// ---------------------------------------------------------------------------
module imd_div #(
  parameter int DW = 54,  // dividend width, above QUOT_W
  parameter int VW = 22   // divisor width, equal to DW - QUOT_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DW-1:0]               num_i,
  input  logic [VW-1:0]               den_i,
  output logic                        done_o,
  output logic [imd_pkg::QUOT_W-1:0]  quot_o
);

  localparam int QW    = imd_pkg::QUOT_W;
  localparam int CNT_W = $clog2(QW);

  logic [VW-1:0]    den_q;
  logic [VW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    low_q, low_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [VW:0]      part;
  logic             fits;

  assign part = {rem_q, low_q[QW-1]};
  assign fits = part >= {1'b0, den_q};

  // Trial subtract, quotient bits shift in where dividend bits leave
  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i[DW-1:QW];
      low_d  = num_i[QW-1:0];
      cnt_d  = CNT_W'(QW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? VW'(part - {1'b0, den_q}) : part[VW-1:0];
      low_d = {low_q[QW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
    end
    rem_q <= rem_d;
    low_q <= low_d;
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

@@ hdl/imu_motion_detector.sv @@
// ---------------------------------------------------------------------------
// imu_motion_detector: windowed accel std and gyro rms motion detector
// Accumulates IMU samples over a window and reports motion at its end.
// ---------------------------------------------------------------------------
// One sample per slave-side transaction. A sample flagged valid (while fewer
// than MAX_WINDOW samples have counted) adds its accel magnitude, the
// magnitude squared and the gyro squared norm to three sums; the sample with
// tlast ends the window and yields one master-side transaction with
// accel_std = isqrt((n*S2 - S1^2) / n^2), gyro_rms = isqrt(G / n), the motion
// flag and n; an empty window reports all zeros. A counted sample occupies
// the block while a 16-step serial square unit, a 16-step root unit and a
// 16-step serial multiplier run back to back. A sample that does not count
// leaves the block idle unless it ends the window. The window end runs an
// empty-window check, then three serial multiplications of 16+CW steps, two
// 32-step divisions and two 16-step roots, then the output load (CW = bits
// of the sample count, 11 by default). The result waits in an output
// register, so the next window starts while it is still pending; a window
// end that finds the register still full holds until it drains. Thresholds
// are written through the cfg port (index 0 accel, index 1 gyro) while the
// block is idle, a rule for the user that the block does not enforce.
// ---------------------------------------------------------------------------
module imu_motion_detector #(
  parameter int MAX_WINDOW = imd_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  logic [imd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // imu_valid
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // accel_std (16), gyro_rms (16), valid_count (11), 5 zero bits
  output logic [imd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // moving
  output logic                              m_axis_tuser,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [imd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [imd_pkg::TH_W-1:0]          cfg_data_i
);

  localparam int SW   = imd_pkg::SAMPLE_W;
  localparam int NW   = imd_pkg::NORM_W;
  localparam int RTW  = imd_pkg::ROOT_W;
  localparam int QW   = imd_pkg::QUOT_W;
  localparam int THW  = imd_pkg::TH_W;
  localparam int VCW  = imd_pkg::VCNT_W;
  localparam int CW   = $clog2(MAX_WINDOW + 1);  // sample count
  localparam int S1W  = RTW + CW;                // magnitude sum
  localparam int S2W  = NW + CW;                 // magnitude square sum
  localparam int GW   = NW + CW;                 // gyro square sum
  localparam int PW   = NW + 2 * CW;             // window products
  localparam int VW   = 2 * CW;                  // divisor width
  localparam int CXW  = (CW > VCW) ? CW : VCW;
  localparam int PADW = imd_pkg::OUT_TDATA_W - 2 * RTW - VCW;

  imd_pkg::st_e state_q, state_d;

  // Accumulators and window control
  logic [CW-1:0]  cnt_q;
  logic [S1W-1:0] s1_q;
  logic [S2W-1:0] s2_q;
  logic [GW-1:0]  g_q;
  logic           last_q;
  logic [THW-1:0] th_accel_q, th_gyro_q;
  logic           out_valid_q;

  // Window payload
  logic [PW-1:0]  p_q;
  logic [PW-1:0]  diff_q;
  logic [RTW-1:0] astd_q, grms_q;
  logic [RTW-1:0] out_astd_q, out_grms_q;
  logic [VCW-1:0] out_cnt_q;
  logic           out_mov_q;

  // Handshakes and unit controls
  logic           in_acc;
  logic           take;
  logic           out_load;
  logic           sq_start, sq_done_a, sq_done_g;
  logic [NW-1:0]  norm_a, norm_g;
  logic           rt_start, rt_done;
  logic [NW-1:0]  rt_arg;
  logic [RTW-1:0] root;
  logic           mm_start, mm_done;
  logic [NW-1:0]  mm_prod;
  logic           mw_start, mw_done;
  logic [S2W-1:0] mw_a;
  logic [S1W-1:0] mw_b;
  logic [PW-1:0]  mw_prod;
  logic           dv_start, dv_done;
  logic [PW-1:0]  dv_num;
  logic [VW-1:0]  dv_den;
  logic [QW-1:0]  quot;
  logic [CXW-1:0] cnt_x;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign take   = s_axis_tuser && (cnt_q < CW'(MAX_WINDOW));
  assign cnt_x  = CXW'(cnt_q);

  // Serial units
  imd_sqnorm u_sq_accel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     ($signed(s_axis_tdata[0*SW +: SW])),
    .y_i     ($signed(s_axis_tdata[1*SW +: SW])),
    .z_i     ($signed(s_axis_tdata[2*SW +: SW])),
    .done_o  (sq_done_a),
    .norm_o  (norm_a)
  );

  imd_sqnorm u_sq_gyro (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     ($signed(s_axis_tdata[3*SW +: SW])),
    .y_i     ($signed(s_axis_tdata[4*SW +: SW])),
    .z_i     ($signed(s_axis_tdata[5*SW +: SW])),
    .done_o  (sq_done_g),
    .norm_o  (norm_g)
  );

  imd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .arg_i   (rt_arg),
    .done_o  (rt_done),
    .root_o  (root)
  );

  imd_mul #(
    .AW (RTW),
    .BW (RTW),
    .PW (NW)
  ) u_mul_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (root),
    .b_i     (root),
    .done_o  (mm_done),
    .prod_o  (mm_prod)
  );

  imd_mul #(
    .AW (S2W),
    .BW (S1W),
    .PW (PW)
  ) u_mul_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mw_start),
    .a_i     (mw_a),
    .b_i     (mw_b),
    .done_o  (mw_done),
    .prod_o  (mw_prod)
  );

  imd_div #(
    .DW (PW),
    .VW (VW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quot_o  (quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (take) begin
            state_d = imd_pkg::ST_SQ;
          end else if (s_axis_tlast) begin
            state_d = imd_pkg::ST_WCHK;
          end
        end
      end
      imd_pkg::ST_SQ:   if (sq_done_a && sq_done_g) state_d = imd_pkg::ST_ROOT;
      imd_pkg::ST_ROOT: if (rt_done) state_d = imd_pkg::ST_MSQ;
      imd_pkg::ST_MSQ: begin
        if (mm_done) begin
          state_d = last_q ? imd_pkg::ST_WCHK : imd_pkg::ST_IDLE;
        end
      end
      imd_pkg::ST_WCHK: state_d = (cnt_q == '0) ? imd_pkg::ST_OUT : imd_pkg::ST_WP;
      imd_pkg::ST_WP:   if (mw_done) state_d = imd_pkg::ST_WQ;
      imd_pkg::ST_WQ:   if (mw_done) state_d = imd_pkg::ST_WNN;
      imd_pkg::ST_WNN:  if (mw_done) state_d = imd_pkg::ST_WDA;
      imd_pkg::ST_WDA:  if (dv_done) state_d = imd_pkg::ST_WRA;
      imd_pkg::ST_WRA:  if (rt_done) state_d = imd_pkg::ST_WDG;
      imd_pkg::ST_WDG:  if (dv_done) state_d = imd_pkg::ST_WRG;
      imd_pkg::ST_WRG:  if (rt_done) state_d = imd_pkg::ST_OUT;
      imd_pkg::ST_OUT:  if (out_load) state_d = imd_pkg::ST_IDLE;
      default:          state_d = imd_pkg::ST_IDLE;
    endcase
  end

  // Unit starts and operand selection
  always_comb begin
    s_axis_tready = 1'b0;
    sq_start      = 1'b0;
    rt_start      = 1'b0;
    rt_arg        = norm_a;
    mm_start      = 1'b0;
    mw_start      = 1'b0;
    mw_a          = s2_q;
    mw_b          = S1W'(cnt_q);
    dv_start      = 1'b0;
    dv_num        = diff_q;
    dv_den        = mw_prod[VW-1:0];
    out_load      = 1'b0;
    unique case (state_q)
      imd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        sq_start      = in_acc && take;
      end
      imd_pkg::ST_SQ: begin
        rt_start = sq_done_a && sq_done_g;
        rt_arg   = norm_a;
      end
      imd_pkg::ST_ROOT: mm_start = rt_done;
      imd_pkg::ST_MSQ:  ;
      imd_pkg::ST_WCHK: begin
        mw_start = (cnt_q != '0);
        mw_a     = s2_q;
        mw_b     = S1W'(cnt_q);
      end
      imd_pkg::ST_WP: begin
        mw_start = mw_done;
        mw_a     = S2W'(s1_q);
        mw_b     = s1_q;
      end
      imd_pkg::ST_WQ: begin
        mw_start = mw_done;
        mw_a     = S2W'(cnt_q);
        mw_b     = S1W'(cnt_q);
      end
      imd_pkg::ST_WNN: begin
        dv_start = mw_done;
        dv_num   = diff_q;
        dv_den   = mw_prod[VW-1:0];
      end
      imd_pkg::ST_WDA: begin
        rt_start = dv_done;
        rt_arg   = quot;
      end
      imd_pkg::ST_WRA: begin
        dv_start = rt_done;
        dv_num   = PW'(g_q);
        dv_den   = VW'(cnt_q);
      end
      imd_pkg::ST_WDG: begin
        rt_start = dv_done;
        rt_arg   = quot;
      end
      imd_pkg::ST_WRG:  ;
      imd_pkg::ST_OUT:  out_load = !out_valid_q || m_axis_tready;
      default:          ;
    endcase
  end

  // Sequencer, accumulators, thresholds and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imd_pkg::ST_IDLE;
      cnt_q       <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      g_q         <= '0;
      last_q      <= 1'b0;
      th_accel_q  <= imd_pkg::ACCEL_STD_TH_RST;
      th_gyro_q   <= imd_pkg::GYRO_RMS_TH_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Hold the window-end mark of the sample in work
      if (in_acc) begin
        last_q <= s_axis_tlast;
      end
      // Accumulate a counted sample
      if (state_q == imd_pkg::ST_MSQ && mm_done) begin
        cnt_q <= cnt_q + 1'b1;
        s1_q  <= s1_q + S1W'(root);
        s2_q  <= s2_q + S2W'(mm_prod);
        g_q   <= g_q + GW'(norm_g);
      end
      // Clear the sums once the result is handed over
      if (out_load) begin
        cnt_q <= '0;
        s1_q  <= '0;
        s2_q  <= '0;
        g_q   <= '0;
      end
      // Output register valid
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // Threshold writes; other indexes drop
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          imd_pkg::REG_ACCEL_STD_TH: th_accel_q <= cfg_data_i;
          imd_pkg::REG_GYRO_RMS_TH:  th_gyro_q  <= cfg_data_i;
          default:                   ;
        endcase
      end
    end
  end

  // Window arithmetic and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == imd_pkg::ST_WP && mw_done) begin
      p_q <= mw_prod;
    end
    // Clamp a negative variance numerator to zero
    if (state_q == imd_pkg::ST_WQ && mw_done) begin
      diff_q <= (p_q > mw_prod) ? p_q - mw_prod : '0;
    end
    if (state_q == imd_pkg::ST_WCHK && cnt_q == '0) begin
      astd_q <= '0;
      grms_q <= '0;
    end
    if (state_q == imd_pkg::ST_WRA && rt_done) begin
      astd_q <= root;
    end
    if (state_q == imd_pkg::ST_WRG && rt_done) begin
      grms_q <= root;
    end
    if (out_load) begin
      out_astd_q <= astd_q;
      out_grms_q <= grms_q;
      out_cnt_q  <= cnt_x[VCW-1:0];
      out_mov_q  <= (astd_q > th_accel_q) || (grms_q > th_gyro_q);
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PADW{1'b0}}, out_cnt_q, out_grms_q, out_astd_q};
  assign m_axis_tuser  = out_mov_q;

endmodule
